// ===== src/sirf_pkg.sv =====
// Package for the signed integer radix formatter.
// Holds widths, character codes, register indexes and the controller/datapath structs.
// No dependencies.
package sirf_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned BASE_SIZE_W  = 5;
  localparam int unsigned SYM_COUNT    = 16;
  localparam int unsigned SYM_REG_W    = 64;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned MAX_BASE_DEF = 16;

  // Long division retires this many dividend bits per cycle.
  localparam int unsigned STEP_BITS    = 8;
  localparam int unsigned DIV_STEPS    = WORD_W / STEP_BITS;
  localparam int unsigned STEP_CNT_W   = $clog2(DIV_STEPS);

  // A 32-bit magnitude has at most 32 digits, reached in base two.
  localparam int unsigned MAX_DIGITS   = WORD_W;
  localparam int unsigned DIGIT_IDX_W  = $clog2(MAX_DIGITS);
  localparam int unsigned DIGIT_CNT_W  = DIGIT_IDX_W + 1;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] PRINT_LO   = 8'd32;
  localparam logic [CHAR_W-1:0] PRINT_HI   = 8'd126;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_SIZE    = 2'd0,
    CFG_SYMBOLS_LOW  = 2'd1,
    CFG_SYMBOLS_HIGH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic alpha_ok;
    logic step_last;
    logic quot_zero;
    logic neg;
    logic rd_last;
    logic out_free;
  } status_t;

endpackage

// ===== src/sirf_alpha_check.sv =====
// Alphabet validity check for the radix formatter.
// Depends on sirf_pkg.
module sirf_alpha_check #(
  parameter int unsigned MAX_BASE = sirf_pkg::MAX_BASE_DEF
) (
  input  logic [sirf_pkg::BASE_SIZE_W-1:0]             base_size_i,
  input  logic [sirf_pkg::SYM_COUNT*sirf_pkg::CHAR_W-1:0] symbols_i,
  output logic                                          ok_o
);

  logic [sirf_pkg::CHAR_W-1:0] sym [sirf_pkg::SYM_COUNT];
  logic                        bad;

  always_comb begin
    for (int i = 0; i < sirf_pkg::SYM_COUNT; i++) begin
      sym[i] = symbols_i[i*sirf_pkg::CHAR_W +: sirf_pkg::CHAR_W];
    end
  end

  // Only symbols below the radix take part in the check.
  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < sirf_pkg::SYM_COUNT; i++) begin
      if (sirf_pkg::BASE_SIZE_W'(i) < base_size_i) begin
        if (sym[i] < sirf_pkg::PRINT_LO || sym[i] > sirf_pkg::PRINT_HI ||
            sym[i] == sirf_pkg::CHAR_PLUS || sym[i] == sirf_pkg::CHAR_MINUS) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < sirf_pkg::SYM_COUNT; j++) begin
          if (sirf_pkg::BASE_SIZE_W'(j) < base_size_i && sym[j] == sym[i]) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

  assign ok_o = !bad && (base_size_i >= sirf_pkg::BASE_SIZE_W'(2)) &&
                (base_size_i <= sirf_pkg::BASE_SIZE_W'(MAX_BASE));

endmodule

// ===== src/sirf_datapath.sv =====
// Datapath of the radix formatter: configuration registers, digit divider,
// digit stack and output register. Depends on sirf_pkg and sirf_alpha_check.
module sirf_datapath #(
  parameter int unsigned MAX_BASE = sirf_pkg::MAX_BASE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sirf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sirf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic signed [sirf_pkg::WORD_W-1:0] number_i,
  input  sirf_pkg::cmd_t                    cmd_i,
  output sirf_pkg::status_t                 status_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sirf_pkg::CHAR_W-1:0]       character_o,
  output logic                              last_char_o
);

  localparam int unsigned DW = $clog2(MAX_BASE);
  localparam int unsigned RW = DW + 1;

  logic [sirf_pkg::BASE_SIZE_W-1:0] base_size_q;
  logic [sirf_pkg::SYM_REG_W-1:0]   symbols_low_q, symbols_high_q;
  logic [sirf_pkg::SYM_COUNT*sirf_pkg::CHAR_W-1:0] symbols_all;
  logic                             alpha_ok;

  logic [sirf_pkg::WORD_W-1:0]      mag_q, mag_d, raw;
  logic [RW-1:0]                    rem_q, rem_d;
  logic                             neg_q;
  logic [sirf_pkg::STEP_CNT_W-1:0]  step_q;
  logic                             step_last;

  logic [DW-1:0]                    digits_q [sirf_pkg::MAX_DIGITS];
  logic [sirf_pkg::DIGIT_CNT_W-1:0] cnt_q, cnt_m1;
  logic [sirf_pkg::DIGIT_IDX_W-1:0] rd_idx;
  logic [DW-1:0]                    rd_digit;

  logic                             out_valid_q, last_q;
  logic [sirf_pkg::CHAR_W-1:0]      char_q;
  logic                             out_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_size_q    <= '0;
      symbols_low_q  <= '0;
      symbols_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sirf_pkg::CFG_BASE_SIZE:    base_size_q    <= cfg_data_i[sirf_pkg::BASE_SIZE_W-1:0];
        sirf_pkg::CFG_SYMBOLS_LOW:  symbols_low_q  <= cfg_data_i;
        sirf_pkg::CFG_SYMBOLS_HIGH: symbols_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign symbols_all = {symbols_high_q, symbols_low_q};

  sirf_alpha_check #(
    .MAX_BASE (MAX_BASE)
  ) u_alpha_check (
    .base_size_i (base_size_q),
    .symbols_i   (symbols_all),
    .ok_o        (alpha_ok)
  );

  assign raw = number_i;

  // One slice of restoring long division: STEP_BITS quotient bits per cycle.
  always_comb begin
    logic [RW-1:0]                  part;
    logic [RW-1:0]                  radix;
    logic [sirf_pkg::STEP_BITS-1:0] qbits;
    radix = base_size_q[RW-1:0];
    rem_d = (step_q == '0) ? '0 : rem_q;
    qbits = '0;
    for (int k = 0; k < sirf_pkg::STEP_BITS; k++) begin
      part = {rem_d[DW-1:0], mag_q[sirf_pkg::WORD_W-1-k]};
      if (part >= radix) begin
        rem_d = part - radix;
        qbits[sirf_pkg::STEP_BITS-1-k] = 1'b1;
      end else begin
        rem_d = part;
      end
    end
    mag_d = {mag_q[sirf_pkg::WORD_W-sirf_pkg::STEP_BITS-1:0], qbits};
  end

  assign step_last = (step_q == sirf_pkg::STEP_CNT_W'(sirf_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
    end else if (cmd_i.load) begin
      step_q <= '0;
      cnt_q  <= '0;
      neg_q  <= raw[sirf_pkg::WORD_W-1];
    end else if (cmd_i.div_step) begin
      step_q <= step_q + 1'b1;
      if (step_last) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end else if (cmd_i.emit_digit) begin
      cnt_q <= cnt_m1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= raw[sirf_pkg::WORD_W-1] ? (sirf_pkg::WORD_W'(0) - raw) : raw;
    end else if (cmd_i.div_step) begin
      mag_q <= mag_d;
      rem_q <= rem_d;
    end
  end

  // Digit stack: filled least significant first, drained from the top.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step && step_last) begin
      digits_q[cnt_q[sirf_pkg::DIGIT_IDX_W-1:0]] <= rem_d[DW-1:0];
    end
  end

  assign cnt_m1   = cnt_q - 1'b1;
  assign rd_idx   = cnt_m1[sirf_pkg::DIGIT_IDX_W-1:0];
  assign rd_digit = digits_q[rd_idx];

  // Output register.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_sign || cmd_i.emit_digit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      char_q <= sirf_pkg::CHAR_MINUS;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= symbols_all[{4'(rd_digit), 3'b000} +: sirf_pkg::CHAR_W];
      last_q <= (cnt_q == sirf_pkg::DIGIT_CNT_W'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_char_o = last_q;

  assign status_o.alpha_ok  = alpha_ok;
  assign status_o.step_last = step_last;
  assign status_o.quot_zero = (mag_d == '0);
  assign status_o.neg       = neg_q;
  assign status_o.rd_last   = (cnt_q == sirf_pkg::DIGIT_CNT_W'(1));
  assign status_o.out_free  = out_free;

endmodule

// ===== src/sirf_ctrl.sv =====
// Controller of the radix formatter: sequences divide, sign and digit output.
// Depends on sirf_pkg.
module sirf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sirf_pkg::status_t status_i,
  output sirf_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIVIDE = 4'b0010,
    ST_SIGN   = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        // An item taken with a bad alphabet is simply dropped.
        if (in_valid_i && status_i.alpha_ok) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.step_last && status_i.quot_zero) begin
          state_d = status_i.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (status_i.rd_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/signed_integer_radix_formatter.sv =====
// Signed 32-bit integer to text in a configurable radix, one character per beat.
// A number is taken only while idle, so the next one waits until the last character
// of the previous one is in the output register. Digits come from the 8-bit-per-cycle
// long divider, one output beat a character. Reset (asynchronous, active low) clears
// the config, control and output-valid registers; the alphabet is then invalid.
// Depends on sirf_pkg, sirf_ctrl, sirf_datapath and sirf_alpha_check.
module signed_integer_radix_formatter #(
  parameter int unsigned MAX_BASE = sirf_pkg::MAX_BASE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sirf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sirf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [sirf_pkg::WORD_W-1:0] number_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [sirf_pkg::CHAR_W-1:0]        character_o,
  output logic                               last_char_o
);

  // The controller and datapath talk only through these two structs.
  sirf_pkg::cmd_t    cmd;
  sirf_pkg::status_t status;

  // The controller takes a number only while idle. With a good alphabet it
  // runs the divider until the quotient reaches zero, pushing one digit after
  // each full pass of the long division, then emits the sign if needed and pops digits most
  // significant first. Each character waits in the output register, so a
  // stalled receiver only holds the sequencer, never the data.
  sirf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the configuration registers, the alphabet check, the
  // long divider, a 32-deep digit stack and the output register.
  sirf_datapath #(
    .MAX_BASE (MAX_BASE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .number_i    (number_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_char_o (last_char_o)
  );

  // Every beat carries a printable character, since the alphabet was checked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o >= sirf_pkg::PRINT_LO && character_o <= sirf_pkg::PRINT_HI))
    else $error("non-printable character on output");

  // The sign is only ever emitted for a negative number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_sign |-> status.neg)
    else $error("sign emitted for a non-negative number");

  // Once a number is loaded the block stops taking input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> in_stall_o)
    else $error("input not stalled after loading a number");

  // Emitting the last digit returns the block to idle at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_digit && status.rd_last) |=> !in_stall_o)
    else $error("block not idle after the final character");

endmodule

// ===== tb/signed_integer_radix_formatter_test.sv =====
// Self-checking testbench for signed_integer_radix_formatter: numbers in, text beats out.
// Keeps its own model of the alphabet check and the digit conversion, and compares each
// character beat with it. Depends on sirf_pkg and the formatter RTL only.
module signed_integer_radix_formatter_test;

  localparam int unsigned MAX_RADIX     = sirf_pkg::MAX_BASE_DEF;
  // This settle time is meant to outlast the slowest number (32 digits plus a sign),
  // so after it the block has certainly finished with anything it took.
  localparam int          SETTLE_CYCLES = 200;
  localparam int          CYCLE_LIMIT   = 800000;
  localparam int          REPORT_LIMIT  = 10;

  typedef logic [2*sirf_pkg::SYM_REG_W-1:0] symbol_set_t;

  // One expected character beat.
  typedef struct packed {
    logic [sirf_pkg::CHAR_W-1:0] code;
    logic                        ends_text;
  } char_beat_t;

  // One number waiting to be sent. With hold_back set the sender holds it back until
  // the text of every earlier number has come out.
  typedef struct {
    logic signed [sirf_pkg::WORD_W-1:0] value;
    logic                               hold_back;
  } number_job_t;

  logic                               clk       = 1'b0;
  logic                               rst_n     = 1'b0;
  logic                               cfg_we    = 1'b0;
  sirf_pkg::cfg_idx_e                 cfg_idx   = sirf_pkg::CFG_BASE_SIZE;
  logic [sirf_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;
  logic                               num_valid = 1'b0;
  logic                               num_stall;
  logic signed [sirf_pkg::WORD_W-1:0] number    = '0;
  logic                               chr_valid;
  logic                               chr_stall = 1'b0;
  logic [sirf_pkg::CHAR_W-1:0]        chr;
  logic                               chr_last;

  // Our copy of the configuration registers.
  logic [sirf_pkg::BASE_SIZE_W-1:0]   alpha_radix = '0;
  logic [sirf_pkg::SYM_REG_W-1:0]     alpha_low   = '0;
  logic [sirf_pkg::SYM_REG_W-1:0]     alpha_high  = '0;

  number_job_t              pending[$];
  char_beat_t               char_due[$];
  char_beat_t               due_beat;

  int                       send_idle_pct    = 0;
  int                       take_stall_pct   = 0;
  int                       numbers_taken    = 0;
  int                       chars_checked    = 0;
  int                       mismatches       = 0;
  int                       alphabets_tried  = 0;
  int                       alphabets_bad    = 0;
  int                       cycle_count      = 0;

  signed_integer_radix_formatter #(
    .MAX_BASE(MAX_RADIX)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (num_valid),
    .in_stall_o (num_stall),
    .number_i   (number),
    .out_valid_o(chr_valid),
    .out_stall_i(chr_stall),
    .character_o(chr),
    .last_char_o(chr_last)
  );

  always #2 clk = ~clk;

  // Symbol for one digit value, taken from our copy of the symbol registers.
  function automatic logic [sirf_pkg::CHAR_W-1:0] symbol_for(int unsigned d);
    if (d < 8) begin
      return alpha_low[sirf_pkg::CHAR_W*d +: sirf_pkg::CHAR_W];
    end else begin
      return alpha_high[sirf_pkg::CHAR_W*(d-8) +: sirf_pkg::CHAR_W];
    end
  endfunction

  // The alphabet is usable only if the radix lies in 2..MAX_RADIX and each of its first
  // radix symbols is printable, is neither sign character and appears only once.
  // Symbols past the radix play no part.
  function automatic logic alphabet_usable();
    logic [sirf_pkg::CHAR_W-1:0] c;
    if (alpha_radix < 2 || alpha_radix > MAX_RADIX) return 1'b0;
    for (int i = 0; i < alpha_radix; i++) begin
      c = symbol_for(i);
      if (c < sirf_pkg::PRINT_LO || c > sirf_pkg::PRINT_HI ||
          c == sirf_pkg::CHAR_PLUS || c == sirf_pkg::CHAR_MINUS) return 1'b0;
      for (int j = i + 1; j < alpha_radix; j++) begin
        if (symbol_for(j) == c) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Works out the text of one number and appends its character beats to char_due.
  // The magnitude is unsigned, so the most negative number needs no special handling.
  function automatic void format_number(logic [sirf_pkg::WORD_W-1:0] value);
    logic [sirf_pkg::WORD_W-1:0] magnitude;
    logic [sirf_pkg::WORD_W-1:0] radix;
    int unsigned                 digit [sirf_pkg::MAX_DIGITS];
    int                          count;
    if (!alphabet_usable()) return;
    radix     = sirf_pkg::WORD_W'(alpha_radix);
    magnitude = value[sirf_pkg::WORD_W-1] ? (~value + 1'b1) : value;
    count     = 0;
    do begin
      digit[count] = magnitude % radix;
      magnitude    = magnitude / radix;
      count++;
    end while (magnitude != 0);
    if (value[sirf_pkg::WORD_W-1]) char_due.push_back('{sirf_pkg::CHAR_MINUS, 1'b0});
    for (int k = count - 1; k >= 0; k--) begin
      char_due.push_back('{symbol_for(digit[k]), k == 0});
    end
  endfunction

  // Symbols from a string, digit 0 first; the bytes past the string are random and
  // should be ignored by the block.
  function automatic symbol_set_t pack_symbols(string s);
    symbol_set_t syms;
    for (int i = 0; i < sirf_pkg::SYM_COUNT; i++) begin
      syms[sirf_pkg::CHAR_W*i +: sirf_pkg::CHAR_W] =
        (i < s.len()) ? s[i] : sirf_pkg::CHAR_W'($urandom);
    end
    return syms;
  endfunction

  // A valid alphabet of the given size with random distinct printable symbols,
  // followed by random bytes of any value.
  function automatic symbol_set_t random_alphabet(int unsigned radix);
    symbol_set_t                 syms;
    logic [255:0]                taken;
    logic [sirf_pkg::CHAR_W-1:0] c;
    taken = '0;
    for (int i = 0; i < sirf_pkg::SYM_COUNT; i++) begin
      if (i < radix) begin
        do c = sirf_pkg::CHAR_W'($urandom_range(sirf_pkg::PRINT_HI, sirf_pkg::PRINT_LO));
        while (taken[c] || c == sirf_pkg::CHAR_PLUS || c == sirf_pkg::CHAR_MINUS);
        taken[c] = 1'b1;
      end else begin
        c = sirf_pkg::CHAR_W'($urandom);
      end
      syms[sirf_pkg::CHAR_W*i +: sirf_pkg::CHAR_W] = c;
    end
    return syms;
  endfunction

  // Sender. A beat is taken at an edge where valid is high and stall is low, and that
  // is when its expected text is worked out. A new number is only presented once the
  // previous one has gone, so a stalled beat stays as it is.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      num_valid <= 1'b0;
      number    <= '0;
    end else begin
      if (num_valid && !num_stall) begin
        format_number(number);
        numbers_taken++;
      end
      if (!num_valid || !num_stall) begin
        if (pending.size() != 0 && !(pending[0].hold_back && char_due.size() != 0)
            && $urandom_range(99) >= send_idle_pct) begin
          number    <= pending[0].value;
          num_valid <= 1'b1;
          void'(pending.pop_front());
        end else begin
          num_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Each character beat taken is checked against the oldest expectation;
  // the stall is drawn afresh every cycle.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      chr_stall <= 1'b0;
    end else begin
      if (chr_valid && !chr_stall) begin
        chars_checked++;
        if (char_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("error: character 0x%h last %b arrived with nothing expected",
                     chr, chr_last);
          end
        end else begin
          due_beat = char_due.pop_front();
          if (chr !== due_beat.code || chr_last !== due_beat.ends_text) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("error: character expected 0x%h got 0x%h, last expected %b got %b",
                       due_beat.code, chr, due_beat.ends_text, chr_last);
            end
          end
        end
      end
      chr_stall <= $urandom_range(99) < take_stall_pct;
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("error: run stopped after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Waits until every number has been sent and its text has come out, then lets the
  // block finish anything that produces no text (a rejected alphabet gives none).
  task automatic settle_block();
    do @(negedge clk);
    while (pending.size() != 0 || num_valid || char_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(sirf_pkg::cfg_idx_e reg_idx,
                           logic [sirf_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= reg_idx;
    cfg_data <= data;
    case (reg_idx)
      sirf_pkg::CFG_BASE_SIZE:    alpha_radix = data[sirf_pkg::BASE_SIZE_W-1:0];
      sirf_pkg::CFG_SYMBOLS_LOW:  alpha_low   = data;
      sirf_pkg::CFG_SYMBOLS_HIGH: alpha_high  = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sets a new radix and alphabet once the block is quiet. The upper bits of the
  // radix write are random, since only the low bits form the register.
  task automatic set_alphabet(int unsigned radix, symbol_set_t syms);
    logic [sirf_pkg::CFG_DATA_W-1:0] data;
    settle_block();
    data                             = {$urandom, $urandom};
    data[sirf_pkg::BASE_SIZE_W-1:0]  = radix[sirf_pkg::BASE_SIZE_W-1:0];
    write_reg(sirf_pkg::CFG_BASE_SIZE, data);
    write_reg(sirf_pkg::CFG_SYMBOLS_LOW, syms[sirf_pkg::SYM_REG_W-1:0]);
    write_reg(sirf_pkg::CFG_SYMBOLS_HIGH,
              syms[2*sirf_pkg::SYM_REG_W-1:sirf_pkg::SYM_REG_W]);
    alphabets_tried++;
    if (!alphabet_usable()) alphabets_bad++;
  endtask

  task automatic queue_number(logic [sirf_pkg::WORD_W-1:0] value, logic hold_back = 1'b0);
    pending.push_back('{value, hold_back});
  endtask

  initial begin
    int unsigned                 radix;
    int unsigned                 pos;
    symbol_set_t                 syms;
    logic [sirf_pkg::WORD_W-1:0] value;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 29;
    take_stall_pct = 66;

    // Straight after reset the radix is zero, so the alphabet is rejected.
    queue_number(5);

    // Decimal: zero, small values either side of zero, and both ends of the range.
    // The most negative number has no positive counterpart in 32 bits.
    set_alphabet(10, pack_symbols("0123456789"));
    queue_number(0);
    queue_number(1);
    queue_number(-1);
    queue_number(9);
    queue_number(-10);
    queue_number(32'h7FFF_FFFF);
    queue_number(32'h8000_0000);

    // Binary gives the longest texts: 32 digits, plus the sign.
    set_alphabet(2, pack_symbols("01"));
    queue_number(32'h8000_0000);
    queue_number(32'h7FFF_FFFF);
    queue_number(-1);

    // Full radix with the printable limits as digits: space for zero, tilde for fifteen.
    set_alphabet(16, pack_symbols(" 123456789ABCDE~"));
    queue_number(0);
    queue_number(32'h8000_0000);
    queue_number(32'h7FFF_FFFF);

    // Signs sitting past the radix are ignored.
    set_alphabet(3, pack_symbols("abc+-"));
    queue_number(-5);

    // Rejected alphabets: radix one, radix above the maximum, radix at the top of
    // the register, a sign among the symbols, unprintable symbols and repeats.
    set_alphabet(1, pack_symbols("0"));
    queue_number(7);
    set_alphabet(17, pack_symbols("0123456789abcdef"));
    queue_number(17);
    set_alphabet(31, pack_symbols("0123456789abcdef"));
    queue_number(-31);
    set_alphabet(3, pack_symbols("01+"));
    queue_number(3);
    set_alphabet(3, pack_symbols("0-1"));
    queue_number(-3);
    syms = pack_symbols("0123");
    syms[sirf_pkg::CHAR_W*2 +: sirf_pkg::CHAR_W]  = sirf_pkg::PRINT_LO - 1'b1;
    set_alphabet(4, syms);
    queue_number(4);
    syms = pack_symbols("0123456789abcdef");
    syms[sirf_pkg::CHAR_W*15 +: sirf_pkg::CHAR_W] = sirf_pkg::PRINT_HI + 1'b1;
    set_alphabet(16, syms);
    queue_number(100);
    syms = pack_symbols("01");
    syms[sirf_pkg::CHAR_W*1 +: sirf_pkg::CHAR_W]  = 8'hC1;
    set_alphabet(2, syms);
    queue_number(2);
    set_alphabet(4, pack_symbols("abca"));
    queue_number(12);
    set_alphabet(16, pack_symbols("0123456789abcde0"));
    queue_number(1);

    // Random part in three rounds: sender idles less than the receiver stalls, then
    // the reverse, then both run flat out. Most settings are valid alphabets with a
    // burst of numbers; about one in six is a broken alphabet with a few numbers.
    for (int round = 0; round < 3; round++) begin
      case (round)
        0:       begin send_idle_pct = 29; take_stall_pct = 66; end
        1:       begin send_idle_pct = 66; take_stall_pct = 29; end
        default: begin send_idle_pct = 0;  take_stall_pct = 0;  end
      endcase
      for (int phase = 0; phase < 10; phase++) begin
        radix = ($urandom_range(3) == 0) ? 2 : $urandom_range(MAX_RADIX, 2);
        syms  = random_alphabet(radix);
        if ($urandom_range(5) == 0) begin
          pos = $urandom_range(radix - 1);
          case ($urandom_range(4))
            0: radix = $urandom_range(1);
            1: radix = $urandom_range((1 << sirf_pkg::BASE_SIZE_W) - 1, MAX_RADIX + 1);
            2: begin
              pos = $urandom_range(radix - 1, 1);
              syms[sirf_pkg::CHAR_W*pos +: sirf_pkg::CHAR_W] =
                syms[sirf_pkg::CHAR_W*$urandom_range(pos - 1) +: sirf_pkg::CHAR_W];
            end
            3: syms[sirf_pkg::CHAR_W*pos +: sirf_pkg::CHAR_W] =
                 $urandom_range(1) ? sirf_pkg::CHAR_PLUS : sirf_pkg::CHAR_MINUS;
            default: syms[sirf_pkg::CHAR_W*pos +: sirf_pkg::CHAR_W] = $urandom_range(1) ?
                       sirf_pkg::CHAR_W'($urandom_range(sirf_pkg::PRINT_LO - 1)) :
                       sirf_pkg::CHAR_W'($urandom_range(255, sirf_pkg::PRINT_HI + 1));
          endcase
          set_alphabet(radix, syms);
          repeat (3) queue_number($urandom);
        end else begin
          set_alphabet(radix, syms);
          for (int k = 0; k < 15; k++) begin
            case ($urandom_range(5))
              0: value = $urandom_range(40);
              1: value = -$urandom_range(40);
              2: case ($urandom_range(3))
                   0:       value = 32'h8000_0000;
                   1:       value = 32'h7FFF_FFFF;
                   2:       value = 32'h8000_0001;
                   default: value = radix;
                 endcase
              default: value = $urandom;
            endcase
            // Now and then the sender waits for the block to empty before a number.
            queue_number(value, k == 6 && $urandom_range(2) == 0);
          end
        end
      end
    end

    settle_block();
    // Anything still expected at this point never arrived.
    mismatches += char_due.size();
    $display("Formatted %0d numbers under %0d alphabet settings, %0d of them rejected.",
             numbers_taken, alphabets_tried, alphabets_bad);
    $display("Checked %0d character beats, %0d mismatches.", chars_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
